@@ sv/rtcc_pkg.sv @@
// Shared widths, opcodes and calendar helpers for the RTC calendar counter.
package rtcc_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned YIC_W   = 7;
  localparam int unsigned CENT_W  = 8;
  localparam int unsigned CENT_OUT_W = 7;

  localparam logic [OP_W-1:0] OP_READ = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

  localparam logic [SEC_W-1:0]   SEC_MAX   = 6'd59;
  localparam logic [MIN_W-1:0]   MIN_MAX   = 6'd59;
  localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
  localparam logic [YIC_W-1:0]   YIC_MAX   = 7'd99;
  localparam logic [CENT_W-1:0]  CENT_MAX  = 8'd99;

  // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_PW    = YEAR_W + 13;

  localparam logic [MONTH_W-1:0] M_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] M_APR = 4'd4;
  localparam logic [MONTH_W-1:0] M_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] M_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] M_NOV = 4'd11;

  // Control bundle handed to each counter cell.
  typedef struct packed {
    logic inc;
    logic force_wrap;
    logic load;
  } cell_ctl_t;

  // Leap test on the split year: y % 400 == 0 iff yic == 0 and cent % 4 == 0.
  function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                   input logic [YIC_W-1:0] yic);
    logic r;
    r = ((yic[1:0] == 2'd0) && (yic != '0)) ||
        ((yic == '0) && (cent[1:0] == 2'd0));
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      M_FEB:                       len = leap ? 5'd29 : 5'd28;
      M_APR, M_JUN, M_SEP, M_NOV:  len = 5'd30;
      default:                     len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ sv/rtcc_if.sv @@
// Valid/ready channel interfaces for operation items and result items.
interface rtcc_in_if;
  import rtcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [YEAR_W-1:0]    load_year;
  logic [MONTH_W-1:0]   load_month;
  logic [DAY_W-1:0]     load_day;
  logic [HOUR_W-1:0]    load_hour;
  logic [MIN_W-1:0]     load_minute;
  logic [SEC_W-1:0]     load_second;

  modport source (output valid, opcode, load_year, load_month, load_day,
                  load_hour, load_minute, load_second, input ready);
  modport sink   (input valid, opcode, load_year, load_month, load_day,
                  load_hour, load_minute, load_second, output ready);
endinterface

interface rtcc_out_if;
  import rtcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CENT_OUT_W-1:0] year_century;
  logic [YIC_W-1:0]      year_in_century;
  logic [MONTH_W-1:0]    month_now;
  logic [DAY_W-1:0]      day_now;
  logic [HOUR_W-1:0]     hour_now;
  logic [MIN_W-1:0]      minute_now;
  logic [SEC_W-1:0]      second_now;

  modport source (output valid, year_century, year_in_century, month_now, day_now,
                  hour_now, minute_now, second_now, input ready);
  modport sink   (input valid, year_century, year_in_century, month_now, day_now,
                  hour_now, minute_now, second_now, output ready);
endinterface

@@ sv/rtcc_cell.sv @@
// One wrapping counter cell of the calendar chain.
module rtcc_cell #(
  parameter int unsigned W = 6,
  parameter logic [W-1:0] RST_VAL = '0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rtcc_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]        hi,
  input  logic [W-1:0]        lo,
  input  logic [W-1:0]        wrap_to,
  input  logic [W-1:0]        ld_val,
  output logic [W-1:0]        val_r,
  output logic [W-1:0]        val_nxt,
  output logic                carry
);
  import rtcc_pkg::*;

  logic wrap;

  // Compare the held value so that out-of-range loads still wrap.
  assign wrap  = (val_r >= hi) || (val_r < lo) || ctl.force_wrap;
  assign carry = ctl.inc && wrap;

  always_comb begin
    if (ctl.load) begin
      val_nxt = ld_val;
    end else if (carry) begin
      val_nxt = wrap_to;
    end else if (ctl.inc) begin
      val_nxt = val_r + W'(1);
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= RST_VAL;
    end else begin
      val_r <= val_nxt;
    end
  end

endmodule

@@ sv/rtcc_split.sv @@
// Splits a loaded year into century and year-in-century by reciprocal multiply.
module rtcc_split (
  input  logic [rtcc_pkg::YEAR_W-1:0] year,
  output logic [rtcc_pkg::CENT_W-1:0] cent,
  output logic [rtcc_pkg::YIC_W-1:0]  yic
);
  import rtcc_pkg::*;

  logic [DIV100_PW-1:0] prod;
  logic [YEAR_W-1:0]    q100;

  assign prod = DIV100_PW'(year) * DIV100_PW'(DIV100_MUL);
  assign cent = prod[DIV100_SHIFT +: CENT_W];
  // cent * 100 as shifts and adds
  assign q100 = YEAR_W'({cent, 6'b0}) + YEAR_W'({cent, 5'b0}) + YEAR_W'({cent, 2'b0});
  assign yic  = YIC_W'(year - q100);

endmodule

@@ sv/rtc_calendar_counter.sv @@
// The result of an accepted item is registered in the output buffer and shown on out_ch
// from its head. Throughput: one item per cycle while the skid slot is empty; the carry
// ripples second to year through a row of counter cells in the same cycle, and a
// two-entry output buffer keeps in_ch ready while one result waits. Reset clears the
// time to 00:00:00, 1 January 2000 and empties the output buffer.
module rtc_calendar_counter (
  input  logic        clk,
  input  logic        rst_n,
  rtcc_in_if.sink     in_ch,
  rtcc_out_if.source  out_ch
);
  import rtcc_pkg::*;

  typedef struct packed {
    logic [CENT_OUT_W-1:0] cent;
    logic [YIC_W-1:0]      yic;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    logic [HOUR_W-1:0]     hour;
    logic [MIN_W-1:0]      minute;
    logic [SEC_W-1:0]      second;
  } result_t;

  logic acc, tick, load;

  logic [SEC_W-1:0]   sec_r,   sec_nxt;
  logic [MIN_W-1:0]   min_r,   min_nxt;
  logic [HOUR_W-1:0]  hour_r,  hour_nxt;
  logic [DAY_W-1:0]   day_r,   day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YIC_W-1:0]   yic_r,   yic_nxt;
  logic [CENT_W-1:0]  cent_r,  cent_nxt;
  logic c_sec, c_min, c_hour, c_day, c_month, c_yic, c_cent;
  logic year_over;
  logic [DAY_W-1:0]   day_hi;
  logic [CENT_W-1:0]  ld_cent;
  logic [YIC_W-1:0]   ld_yic;

  cell_ctl_t ctl_sec, ctl_min, ctl_hour, ctl_day, ctl_month, ctl_yic, ctl_cent;

  result_t res_nxt, main_r, skid_r;
  logic    main_valid_r, skid_valid_r, pop;

  assign in_ch.ready = !skid_valid_r;
  assign acc  = in_ch.valid && in_ch.ready;
  assign tick = acc && (in_ch.opcode == OP_TICK);
  assign load = acc && (in_ch.opcode == OP_LOAD);

  // Years of 10000 and up wrap straight to zero on the next year carry.
  assign year_over = (cent_r > CENT_MAX);
  assign day_hi    = month_len(month_r, is_leap(cent_r, yic_r));

  assign ctl_sec   = '{inc: tick,    force_wrap: 1'b0,      load: load};
  assign ctl_min   = '{inc: c_sec,   force_wrap: 1'b0,      load: load};
  assign ctl_hour  = '{inc: c_min,   force_wrap: 1'b0,      load: load};
  assign ctl_day   = '{inc: c_hour,  force_wrap: 1'b0,      load: load};
  assign ctl_month = '{inc: c_day,   force_wrap: 1'b0,      load: load};
  assign ctl_yic   = '{inc: c_month, force_wrap: year_over, load: load};
  assign ctl_cent  = '{inc: c_yic,   force_wrap: year_over, load: load};

  rtcc_split u_split (.year(in_ch.load_year), .cent(ld_cent), .yic(ld_yic));

  rtcc_cell #(.W(SEC_W), .RST_VAL(6'd0)) u_sec (
    .clk, .rst_n, .ctl(ctl_sec), .hi(SEC_MAX), .lo('0), .wrap_to('0),
    .ld_val(in_ch.load_second), .val_r(sec_r), .val_nxt(sec_nxt), .carry(c_sec));

  rtcc_cell #(.W(MIN_W), .RST_VAL(6'd0)) u_min (
    .clk, .rst_n, .ctl(ctl_min), .hi(MIN_MAX), .lo('0), .wrap_to('0),
    .ld_val(in_ch.load_minute), .val_r(min_r), .val_nxt(min_nxt), .carry(c_min));

  rtcc_cell #(.W(HOUR_W), .RST_VAL(5'd0)) u_hour (
    .clk, .rst_n, .ctl(ctl_hour), .hi(HOUR_MAX), .lo('0), .wrap_to('0),
    .ld_val(in_ch.load_hour), .val_r(hour_r), .val_nxt(hour_nxt), .carry(c_hour));

  rtcc_cell #(.W(DAY_W), .RST_VAL(5'd1)) u_day (
    .clk, .rst_n, .ctl(ctl_day), .hi(day_hi), .lo('0), .wrap_to(5'd1),
    .ld_val(in_ch.load_day), .val_r(day_r), .val_nxt(day_nxt), .carry(c_day));

  // Months outside 1..12 roll to January like December does.
  rtcc_cell #(.W(MONTH_W), .RST_VAL(4'd1)) u_month (
    .clk, .rst_n, .ctl(ctl_month), .hi(MONTH_MAX), .lo(4'd1), .wrap_to(4'd1),
    .ld_val(in_ch.load_month), .val_r(month_r), .val_nxt(month_nxt), .carry(c_month));

  rtcc_cell #(.W(YIC_W), .RST_VAL(7'd0)) u_yic (
    .clk, .rst_n, .ctl(ctl_yic), .hi(YIC_MAX), .lo('0), .wrap_to('0),
    .ld_val(ld_yic), .val_r(yic_r), .val_nxt(yic_nxt), .carry(c_yic));

  rtcc_cell #(.W(CENT_W), .RST_VAL(8'd20)) u_cent (
    .clk, .rst_n, .ctl(ctl_cent), .hi(CENT_MAX), .lo('0), .wrap_to('0),
    .ld_val(ld_cent), .val_r(cent_r), .val_nxt(cent_nxt), .carry(c_cent));

  assign res_nxt = '{cent: cent_nxt[CENT_OUT_W-1:0], yic: yic_nxt, month: month_nxt,
                     day: day_nxt, hour: hour_nxt, minute: min_nxt, second: sec_nxt};

  assign pop = main_valid_r && out_ch.ready;

  // Two-entry output buffer: park the item in the skid slot while the head stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= acc;
      end else begin
        main_valid_r <= acc;
      end
    end else if (acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
        if (acc) begin
          skid_r <= res_nxt;
        end
      end else if (acc) begin
        main_r <= res_nxt;
      end
    end else if (acc) begin
      skid_r <= res_nxt;
    end
  end

  assign out_ch.valid           = main_valid_r;
  assign out_ch.year_century    = main_r.cent;
  assign out_ch.year_in_century = main_r.yic;
  assign out_ch.month_now       = main_r.month;
  assign out_ch.day_now         = main_r.day;
  assign out_ch.hour_now        = main_r.hour;
  assign out_ch.minute_now      = main_r.minute;
  assign out_ch.second_now      = main_r.second;

endmodule
